// ----- hw/rtl/wsce_pkg.sv -----
// shared constants and types for the weighted survival curve estimator
package wsce_pkg;

  localparam int MaxTimesDefault = 64;

  localparam int TimeW  = 7;
  localparam int TreeW  = 17;
  localparam int UnitW  = 16;
  localparam int SurvW  = 17;
  localparam int HistW  = 48;
  localparam int RiskW  = 56;
  localparam int WsumW  = 40;
  localparam int ProdW  = 33;
  localparam int MulW   = 33;
  localparam int RiskSW = 58;
  localparam int HazW   = 39;
  localparam int ApbAW  = 3;
  localparam int ApbDW  = 32;

  localparam logic [TimeW-1:0] NumTimesReset = 7'd64;

  localparam logic RegNumTimes = 1'b0;
  localparam logic RegMode     = 1'b1;

  localparam logic ModeKm = 1'b0;

  localparam logic [32:0] One32  = 33'h1_0000_0000;
  localparam logic [32:0] Recip3 = 33'h0_AAAA_AAAB;

  typedef logic [TimeW-1:0] time_t;

endpackage

// ----- hw/rtl/wsce_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module wsce_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/weighted_survival_curve_estimator_unit.sv -----
// top level of the weighted survival curve estimator
//
// Samples are accumulated into failure and censor histograms held in two ram
// instances; each sample goes through histogram read, weight multiply and
// saturating write back while input is stalled. On the sample flagged last,
// one survival value is produced per time 1..n_eff (num_times clamped to
// 1..MAX_TIMES), or one empty result if the weight sum is zero. A point uses
// bit-serial division when a ratio is needed, a Kaplan-Meier factor multiply,
// and in the Nelson-Aalen mode series evaluation and squaring on the shared
// 33x33 multiplier. After reset and after every curve, a clearing pass over
// all MAX_TIMES+1 entries zeroes the histograms while input is stalled.
module weighted_survival_curve_estimator_unit #(
  parameter int MAX_TIMES = wsce_pkg::MaxTimesDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wsce_pkg::ApbAW-1:0]  paddr,
  input  logic [wsce_pkg::ApbDW-1:0]  pwdata,
  output logic [wsce_pkg::ApbDW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [wsce_pkg::TimeW-1:0]  event_time_i,
  input  logic                        is_event_i,
  input  logic [wsce_pkg::TreeW-1:0]  tree_weight_i,
  input  logic [wsce_pkg::UnitW-1:0]  unit_weight_i,
  input  logic                        last_sample_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [wsce_pkg::SurvW-1:0]  survival_o,
  output logic [wsce_pkg::TimeW-1:0]  time_index_o,
  output logic                        empty_result_o,
  output logic                        last_value_o
);

  import wsce_pkg::*;

  localparam int Depth = MAX_TIMES + 1;
  localparam int AW    = $clog2(Depth);

  typedef enum logic [4:0] {
    StClear, StIdle, StUMul, StUpd, StE0A, StE0B, StFetch, StLatch, StDiv,
    StKMul, StKFin, StExp0, StTMul, StTDiv, StT3, StTAcc, StSq, StSqF, StOut,
    StEmpty
  } state_e;

  state_e state_q;

  logic [TimeW-1:0]  num_times_q;
  logic              mode_q;
  logic [AW-1:0]     addr_q;
  logic              ev_q, last_q;
  logic [TreeW-1:0]  tw_q;
  logic [UnitW-1:0]  uw_q;
  logic [2*MulW-1:0] prod_q;
  logic [RiskW-1:0]  risk_tot_q;
  logic [WsumW-1:0]  wsum_q;
  logic [RiskSW-1:0] risk_q;
  logic [HistW-1:0]  f_q, c_q;
  logic [TimeW-1:0]  time_q;
  logic [32:0]       km_q;
  logic              dead_q;
  logic [HazW-1:0]   haz_q;
  logic [RiskSW-1:0] rem_q;
  logic [31:0]       quo_q;
  logic [4:0]        div_cnt_q;
  logic [32:0]       e_q, t_q;
  logic [2:0]        k_q;
  logic [3:0]        sq_cnt_q;
  logic              out_valid_q;
  logic [SurvW-1:0]  surv_q;
  logic [TimeW-1:0]  tidx_q;
  logic              empty_q, lastv_q;

  // effective curve length and clamped input time
  time_t n_eff, t_clamp;
  always_comb begin
    if (num_times_q == '0) begin
      n_eff = TimeW'(1);
    end else if (int'(num_times_q) > MAX_TIMES) begin
      n_eff = TimeW'(MAX_TIMES);
    end else begin
      n_eff = num_times_q;
    end
    t_clamp = (event_time_i > n_eff) ? n_eff : event_time_i;
  end

  logic            in_acc, out_free;
  logic [AW-1:0]   rd_addr;
  logic [HistW-1:0] fail_rd, cens_rd;
  logic            fail_we, cens_we;
  logic [HistW-1:0] wr_data;
  logic [HistW:0]   hist_sum;
  logic [RiskW:0]   risk_sum;
  logic [WsumW:0]   wsum_sum;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign rd_addr    = (state_q == StIdle) ? AW'(t_clamp) : addr_q;

  assign hist_sum = {1'b0, (ev_q ? fail_rd : cens_rd)} + (HistW+1)'(prod_q[ProdW-1:0]);
  assign risk_sum = {1'b0, risk_tot_q} + (RiskW+1)'(prod_q[ProdW-1:0]);
  assign wsum_sum = {1'b0, wsum_q} + (WsumW+1)'(uw_q);

  always_comb begin
    fail_we = 1'b0;
    cens_we = 1'b0;
    wr_data = '0;
    case (state_q)
      StUpd: begin
        fail_we = ev_q;
        cens_we = !ev_q;
        wr_data = hist_sum[HistW] ? {HistW{1'b1}} : hist_sum[HistW-1:0];
      end
      StClear: begin
        fail_we = 1'b1;
        cens_we = 1'b1;
      end
      default: ;
    endcase
  end

  wsce_ram #(.Width(HistW), .Depth(Depth)) u_fail_ram (
    .clk_i   (clk_i),
    .we_i    (fail_we),
    .waddr_i (addr_q),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (fail_rd)
  );

  wsce_ram #(.Width(HistW), .Depth(Depth)) u_cens_ram (
    .clk_i   (clk_i),
    .we_i    (cens_we),
    .waddr_i (addr_q),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (cens_rd)
  );

  // at-risk amount and ratio comparisons
  logic             risk_pos;
  logic [56:0]      a_val;
  logic [RiskSW-1:0] rem_sh;
  logic             div_take;
  assign risk_pos = !risk_q[RiskSW-1] && (risk_q != '0);
  assign a_val    = risk_q[56:0];
  assign rem_sh   = {rem_q[RiskSW-2:0], 1'b0};
  assign div_take = rem_sh >= {1'b0, a_val};

  // shared multiplier operands
  logic [31:0]     tx;
  logic [MulW-1:0] mul_a, mul_b;
  assign tx = prod_q[63:32];
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StUMul: begin
        mul_a = MulW'(tw_q);
        mul_b = MulW'(uw_q);
      end
      StKMul: begin
        mul_a = km_q;
        mul_b = MulW'(quo_q);
      end
      StTMul: begin
        mul_a = t_q;
        mul_b = MulW'(haz_q[HazW-1:10]);
      end
      StTDiv: begin
        mul_a = MulW'(tx);
        mul_b = Recip3;
      end
      StSq: begin
        mul_a = e_q;
        mul_b = e_q;
      end
      default: ;
    endcase
  end

  logic [32:0] cur_val;
  logic [33:0] rnd_val;
  assign cur_val = (mode_q == ModeKm) ? (dead_q ? 33'd0 : km_q) : e_q;
  assign rnd_val = {1'b0, cur_val} + 34'h8000;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      RegNumTimes: prdata = ApbDW'(num_times_q);
      RegMode:     prdata = ApbDW'(mode_q);
      default:     prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      addr_q      <= '0;
      num_times_q <= NumTimesReset;
      mode_q      <= ModeKm;
      risk_tot_q  <= '0;
      wsum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[2])
          RegNumTimes: num_times_q <= pwdata[TimeW-1:0];
          RegMode:     mode_q <= pwdata[0];
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (state_q inside {StUMul, StKMul, StTMul, StSq}
          || (state_q == StTDiv && k_q == 3'd3)) begin
        prod_q <= mul_a * mul_b;
      end

      case (state_q)
        StClear: begin
          if (addr_q == AW'(MAX_TIMES)) begin
            state_q <= StIdle;
          end else begin
            addr_q <= addr_q + AW'(1);
          end
        end
        StIdle: begin
          if (in_acc) begin
            addr_q  <= AW'(t_clamp);
            ev_q    <= is_event_i;
            last_q  <= last_sample_i;
            tw_q    <= tree_weight_i;
            uw_q    <= unit_weight_i;
            state_q <= StUMul;
          end
        end
        StUMul: state_q <= StUpd;
        StUpd: begin
          risk_tot_q <= risk_sum[RiskW] ? {RiskW{1'b1}} : risk_sum[RiskW-1:0];
          wsum_q     <= wsum_sum[WsumW] ? {WsumW{1'b1}} : wsum_sum[WsumW-1:0];
          if (last_q) begin
            addr_q  <= '0;
            state_q <= StE0A;
          end else begin
            state_q <= StIdle;
          end
        end
        StE0A: state_q <= StE0B;
        StE0B: begin
          risk_q <= {2'b0, risk_tot_q} - RiskSW'(cens_rd);
          km_q   <= One32;
          haz_q  <= '0;
          dead_q <= 1'b0;
          time_q <= TimeW'(1);
          addr_q <= AW'(1);
          if (wsum_q == '0) begin
            state_q <= StEmpty;
          end else begin
            state_q <= StFetch;
          end
        end
        StFetch: state_q <= StLatch;
        StLatch: begin
          f_q       <= fail_rd;
          c_q       <= cens_rd;
          div_cnt_q <= '0;
          quo_q     <= '0;
          state_q   <= StOut;
          if (mode_q == ModeKm) begin
            if (!dead_q && risk_pos && fail_rd != '0) begin
              if ({9'b0, fail_rd} >= a_val) begin
                km_q   <= '0;
                dead_q <= 1'b1;
              end else begin
                rem_q   <= {1'b0, a_val - {9'b0, fail_rd}};
                state_q <= StDiv;
              end
            end
          end else begin
            state_q <= StExp0;
            if (risk_pos) begin
              if ({9'b0, fail_rd} >= a_val) begin
                haz_q <= haz_q + HazW'(One32);
              end else begin
                rem_q   <= RiskSW'(fail_rd);
                state_q <= StDiv;
              end
            end
          end
        end
        StDiv: begin
          rem_q     <= div_take ? (rem_sh - {1'b0, a_val}) : rem_sh;
          quo_q     <= {quo_q[30:0], div_take};
          div_cnt_q <= div_cnt_q + 5'd1;
          if (div_cnt_q == 5'd31) begin
            state_q <= (mode_q == ModeKm) ? StKMul : StExp0;
            if (mode_q != ModeKm) begin
              haz_q <= haz_q + HazW'({quo_q[30:0], div_take});
            end
          end
        end
        StKMul: state_q <= StKFin;
        StKFin: begin
          km_q    <= prod_q[64:32];
          if (prod_q[64:32] == '0) begin
            dead_q <= 1'b1;
          end
          state_q <= StOut;
        end
        StExp0: begin
          e_q      <= One32;
          t_q      <= One32;
          k_q      <= 3'd1;
          sq_cnt_q <= '0;
          state_q  <= StTMul;
        end
        StTMul: state_q <= StTDiv;
        StTDiv: begin
          case (k_q)
            3'd2: begin
              t_q     <= 33'(tx >> 1);
              state_q <= StTAcc;
            end
            3'd3: state_q <= StT3;
            3'd4: begin
              t_q     <= 33'(tx >> 2);
              state_q <= StTAcc;
            end
            default: begin
              t_q     <= 33'(tx);
              state_q <= StTAcc;
            end
          endcase
        end
        StT3: begin
          t_q     <= prod_q[65:33];
          state_q <= StTAcc;
        end
        StTAcc: begin
          e_q <= k_q[0] ? (e_q - t_q) : (e_q + t_q);
          k_q <= k_q + 3'd1;
          state_q <= (k_q == 3'd4) ? StSq : StTMul;
        end
        StSq: begin
          if (sq_cnt_q == 4'd10) begin
            state_q <= StOut;
          end else if (e_q < One32) begin
            state_q <= StSqF;
          end else begin
            sq_cnt_q <= sq_cnt_q + 4'd1;
          end
        end
        StSqF: begin
          e_q      <= 33'((prod_q + 66'h8000_0000) >> 32);
          sq_cnt_q <= sq_cnt_q + 4'd1;
          state_q  <= StSq;
        end
        StOut: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            surv_q      <= rnd_val[32:16];
            tidx_q      <= time_q;
            empty_q     <= 1'b0;
            lastv_q     <= (time_q == n_eff);
            risk_q      <= risk_q - RiskSW'(f_q) - RiskSW'(c_q);
            if (time_q == n_eff) begin
              addr_q     <= '0;
              risk_tot_q <= '0;
              wsum_q     <= '0;
              state_q    <= StClear;
            end else begin
              time_q  <= time_q + TimeW'(1);
              addr_q  <= AW'(time_q + TimeW'(1));
              state_q <= StFetch;
            end
          end
        end
        StEmpty: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            surv_q      <= '0;
            tidx_q      <= '0;
            empty_q     <= 1'b1;
            lastv_q     <= 1'b1;
            addr_q      <= '0;
            risk_tot_q  <= '0;
            wsum_q      <= '0;
            state_q     <= StClear;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign survival_o     = surv_q;
  assign time_index_o   = tidx_q;
  assign empty_result_o = empty_q;
  assign last_value_o   = lastv_q;

endmodule

// ----- verif/tb_weighted_survival_curve_estimator_unit.sv -----
// self-checking testbench for the weighted survival curve estimator unit
module tb_weighted_survival_curve_estimator_unit;
  import wsce_pkg::*;

  typedef struct packed {
    logic [TimeW-1:0] event_time;
    logic             is_event;
    logic [TreeW-1:0] tree_weight;
    logic [UnitW-1:0] unit_weight;
    logic             last_sample;
  } sample_t;

  typedef struct packed {
    logic [SurvW-1:0] survival;
    logic [TimeW-1:0] time_index;
    logic             empty_result;
    logic             last_value;
  } point_t;

  localparam int      NumBuckets = MaxTimesDefault + 1;
  localparam longint  LimitCycles = 20000000;
  localparam longint unsigned Q32One = 64'h1_0000_0000;
  localparam longint unsigned HistCap = (64'd1 << HistW) - 1;
  localparam longint unsigned RiskCap = (64'd1 << RiskW) - 1;
  localparam longint unsigned WsumCap = (64'd1 << WsumW) - 1;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [ApbAW-1:0] paddr;
  logic [ApbDW-1:0] pwdata, prdata;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [TimeW-1:0] event_time_i;
  logic is_event_i, last_sample_i;
  logic [TreeW-1:0] tree_weight_i;
  logic [UnitW-1:0] unit_weight_i;
  logic [SurvW-1:0] survival_o;
  logic [TimeW-1:0] time_index_o;
  logic empty_result_o, last_value_o;

  weighted_survival_curve_estimator_unit dut (.*);

  sample_t pending_samples[$];
  point_t  curve_points[$];
  int      errors = 0;
  bit      calm = 0;
  longint  cycles = 0;

  // predictor state
  longint unsigned fail_hist[NumBuckets];
  longint unsigned cens_hist[NumBuckets];
  longint unsigned risk_sum, weight_sum;
  int unsigned     cfg_times = 64;
  bit              cfg_mode = 0;

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                              longint unsigned cap);
    longint unsigned s;
    s = a + b;
    return (s > cap) ? cap : s;
  endfunction

  function automatic longint unsigned quot32(longint unsigned a, longint unsigned b);
    longint unsigned rem, q;
    rem = a;
    q = 0;
    for (int i = 0; i < 32; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= b) begin
        rem = rem - b;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned neg_exp(longint unsigned h);
    longint unsigned y, e, t;
    y = h >> 10;
    e = Q32One;
    t = Q32One;
    for (int k = 1; k <= 4; k++) begin
      t = ((t * y) >> 32) / k;
      if (k % 2 == 1) e = e - t;
      else e = e + t;
    end
    for (int i = 0; i < 10; i++) begin
      if (e < Q32One) e = (e * e + (Q32One >> 1)) >> 32;
    end
    return e;
  endfunction

  function automatic int unsigned curve_len();
    if (cfg_times == 0) return 1;
    if (cfg_times > MaxTimesDefault) return MaxTimesDefault;
    return cfg_times;
  endfunction

  function automatic void clear_stores();
    for (int i = 0; i < NumBuckets; i++) begin
      fail_hist[i] = 0;
      cens_hist[i] = 0;
    end
    risk_sum = 0;
    weight_sum = 0;
  endfunction

  function automatic void add_sample(sample_t s);
    int unsigned n, t;
    longint unsigned prod, km, haz, val, f, a, fac;
    longint risk;
    bit dead;
    point_t p;
    n = curve_len();
    t = s.event_time;
    if (t > n) t = n;
    prod = longint'(s.tree_weight) * longint'(s.unit_weight);
    if (s.is_event) fail_hist[t] = sat_sum(fail_hist[t], prod, HistCap);
    else cens_hist[t] = sat_sum(cens_hist[t], prod, HistCap);
    risk_sum = sat_sum(risk_sum, prod, RiskCap);
    weight_sum = sat_sum(weight_sum, s.unit_weight, WsumCap);
    if (!s.last_sample) return;
    if (weight_sum == 0) begin
      p = '{survival: '0, time_index: '0, empty_result: 1'b1, last_value: 1'b1};
      curve_points.push_back(p);
      clear_stores();
      return;
    end
    km = Q32One;
    haz = 0;
    dead = 0;
    risk = longint'(risk_sum) - longint'(cens_hist[0]);
    for (int unsigned tm = 1; tm <= n; tm++) begin
      f = fail_hist[tm];
      if (cfg_mode == ModeKm) begin
        if (!dead && risk > 0 && f != 0) begin
          a = longint'(risk);
          fac = (f >= a) ? 0 : quot32(a - f, a);
          km = (km * fac) >> 32;
          if (km == 0) dead = 1;
        end
        val = dead ? 0 : km;
      end else begin
        if (risk > 0) begin
          a = longint'(risk);
          haz = haz + ((f >= a) ? Q32One : quot32(f, a));
        end
        val = neg_exp(haz);
      end
      p.survival = SurvW'((val + 64'h8000) >> 16);
      p.time_index = TimeW'(tm);
      p.empty_result = 1'b0;
      p.last_value = (tm == n);
      curve_points.push_back(p);
      risk = risk - longint'(f) - longint'(cens_hist[tm]);
    end
    clear_stores();
  endfunction

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i)
        add_sample({event_time_i, is_event_i, tree_weight_i, unit_weight_i, last_sample_i});
      if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
        {event_time_i, is_event_i, tree_weight_i, unit_weight_i, last_sample_i}
          <= pending_samples.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    point_t want;
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("** weighted_survival_curve_estimator_unit: FAILED **");
      $finish;
    end
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (curve_points.size() == 0) begin
          $display("%0t unexpected transfer: survival %0d time %0d", $time, survival_o,
                   time_index_o);
          errors++;
        end else begin
          want = curve_points.pop_front();
          if (survival_o !== want.survival) begin
            $display("%0t survival exp %0d act %0d", $time, want.survival, survival_o);
            errors++;
          end
          if (time_index_o !== want.time_index) begin
            $display("%0t time_index exp %0d act %0d", $time, want.time_index, time_index_o);
            errors++;
          end
          if (empty_result_o !== want.empty_result) begin
            $display("%0t empty_result exp %0d act %0d", $time, want.empty_result,
                     empty_result_o);
            errors++;
          end
          if (last_value_o !== want.last_value) begin
            $display("%0t last_value exp %0d act %0d", $time, want.last_value, last_value_o);
            errors++;
          end
        end
      end
      out_stall_i <= !calm && ($urandom_range(99) < 32);
    end
  end

  task automatic apb_write(logic idx, int unsigned value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegNumTimes) cfg_times = value & 7'h7f;
    else cfg_mode = value[0];
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || in_valid_i || curve_points.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic sample_t rand_sample(bit last);
    sample_t s;
    int unsigned n;
    n = curve_len();
    s.event_time = TimeW'(($urandom_range(9) == 0) ? $urandom_range(127)
                                                   : $urandom_range(n + 1));
    s.is_event = 1'($urandom_range(1));
    s.tree_weight = TreeW'(($urandom_range(7) == 0) ? $urandom_range(131071)
                                                    : $urandom_range(65536));
    s.unit_weight = ($urandom_range(11) == 0) ? 16'd0 : UnitW'($urandom_range(65535));
    s.last_sample = last;
    return s;
  endfunction

  task automatic push_set(int unsigned size, bit zero_weight);
    sample_t s;
    for (int unsigned i = 0; i < size; i++) begin
      s = rand_sample(i == size - 1);
      if (zero_weight) s.unit_weight = '0;
      pending_samples.push_back(s);
    end
  endtask

  initial begin
    int unsigned times_list[10];
    bit          mode_list[10];
    int unsigned budget;
    times_list = '{64, 64, 1, 1, 0, 127, 5, 10, 3, 20};
    mode_list  = '{0, 1, 0, 1, 0, 1, 0, 1, 1, 0};
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid_i = 0; out_stall_i = 0;
    event_time_i = '0; is_event_i = 0; tree_weight_i = '0; unit_weight_i = '0;
    last_sample_i = 0;
    clear_stores();
    rst_ni = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, time zero, out of range time, zero weight, full failure
    pending_samples.push_back('{0, 1, 131071, 65535, 0});
    pending_samples.push_back('{0, 0, 65536, 256, 0});
    pending_samples.push_back('{127, 1, 65536, 65535, 0});
    pending_samples.push_back('{64, 0, 1, 1, 0});
    pending_samples.push_back('{3, 1, 65536, 256, 1});
    pending_samples.push_back('{5, 1, 0, 0, 1});
    pending_samples.push_back('{10, 0, 0, 0, 0});
    pending_samples.push_back('{2, 1, 65536, 0, 1});
    pending_samples.push_back('{1, 1, 65536, 256, 1});
    pending_samples.push_back('{2, 1, 65536, 256, 0});
    pending_samples.push_back('{2, 0, 32768, 256, 0});
    pending_samples.push_back('{7, 1, 100, 9, 1});
    pending_samples.push_back('{85, 1, 131071, 65535, 0});
    pending_samples.push_back('{42, 0, 21845, 43690, 1});
    wait_drained();

    foreach (times_list[ph]) begin
      apb_write(RegNumTimes, times_list[ph]);
      apb_write(RegMode, mode_list[ph]);
      calm = (ph == 3);
      budget = 0;
      while (budget < 37) begin
        int unsigned sz;
        sz = $urandom_range(1, 8);
        push_set(sz, $urandom_range(15) == 0);
        budget += sz;
      end
      wait_drained();
    end

    if (errors == 0 && curve_points.size() == 0) begin
      $display("** weighted_survival_curve_estimator_unit: PASSED **");
    end else begin
      $display("** weighted_survival_curve_estimator_unit: FAILED **");
    end
    $finish;
  end

endmodule
